@@ rtl/srpq_pkg.sv @@
`timescale 1ns / 1ps

package srpq_pkg;

	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 16;
	localparam int COUNT_W  = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_PULL   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// One stored entry of the queue.
	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [VALUE_W-1:0]       value;
	} entry_t;

	// Command broadcast to every cell in the chain.
	typedef struct packed {
		logic   ins;
		logic   pull;
		entry_t fresh;
	} cell_cmd_t;

	typedef struct packed {
		op_t                      operation;
		logic [VALUE_W-1:0]       item_value;
		logic signed [PRIO_W-1:0] item_priority;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [VALUE_W-1:0]  pulled_value;
		logic [VALUE_W-1:0]  head_value;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_t;

endpackage

@@ rtl/srpq_cell.sv @@
`timescale 1ns / 1ps

module srpq_cell
	import srpq_pkg::*;
(
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  logic      is_head,
	input  entry_t    up,
	input  logic      up_valid,
	input  entry_t    down,
	input  logic      own_valid,
	output entry_t    entry
);

	entry_t entry_q;
	logic   take_up;
	logic   take_new;

	// The new entry goes here if it outranks this cell or it is empty, but not the one above.
	always_comb begin
		take_up  = cmd.ins && up_valid && ($signed(cmd.fresh.prio) > $signed(up.prio));
		take_new = cmd.ins && !take_up && (is_head || up_valid) &&
			(!own_valid || ($signed(cmd.fresh.prio) > $signed(entry_q.prio)));
	end

	always_ff @(posedge clk) begin
		if (cmd.pull) begin
			entry_q <= down;
		end else if (take_up) begin
			entry_q <= up;
		end else if (take_new) begin
			entry_q <= cmd.fresh;
		end
	end

	assign entry = entry_q;

endmodule

@@ rtl/sorted_ring_priority_queue.sv @@
`timescale 1ns / 1ps

// Bounded priority queue built as a chain of DEPTH cells kept sorted from the
// head cell down by non-increasing priority; equal priorities leave in arrival
// order. An item is accepted on any clock edge where start is high and busy is
// low. Busy never rises, so a new item may be issued every cycle, and each item
// produces exactly one result in the cycle after it is taken, shown for exactly
// one cycle with done high. The receiver cannot stall, so it must take the
// result in that cycle. Every cell compares the incoming priority with its own
// and with its upper neighbor's in parallel and then shifts, holds or loads,
// which is what sets the rate at one item per cycle. head_value and entry_count
// of a result show the queue as that item left it. An insert into a full queue
// and a pull from an empty one change nothing and report their status with a
// pulled value of zero. DEPTH may range from 2 to 31, the largest count the
// entry_count field can hold.

module sorted_ring_priority_queue
	import srpq_pkg::*;
#(
	parameter int DEPTH = 16
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]   count_q;
	logic               done_q;
	status_t            status_q;
	logic [VALUE_W-1:0] pulled_q;

	entry_t    cell_entry [DEPTH];
	logic      cell_valid [DEPTH];
	cell_cmd_t cmd;
	logic      is_full;
	logic      is_empty;

	// The block finishes an item in the cycle it is taken, so it never pushes back.
	assign busy = 1'b0;

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	// A rejected insert or pull becomes a no-op for the whole chain.
	always_comb begin
		cmd.ins         = start && (request.operation == OP_INSERT) && !is_full;
		cmd.pull        = start && (request.operation == OP_PULL) && !is_empty;
		cmd.fresh.prio  = request.item_priority;
		cmd.fresh.value = request.item_value;
	end

	// Occupancy follows from the count: the first count_q cells hold entries.
	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			entry_t up_entry;
			logic   up_ok;
			entry_t down_entry;

			assign cell_valid[i] = (CNT_W'(i) < count_q);

			if (i == 0) begin : g_head
				assign up_entry = cell_entry[0];
				assign up_ok    = 1'b0;
			end else begin : g_body
				assign up_entry = cell_entry[i-1];
				assign up_ok    = cell_valid[i-1];
			end

			// The last cell has no lower neighbor; after a pull it is unoccupied anyway.
			if (i == DEPTH - 1) begin : g_tail
				assign down_entry = cell_entry[i];
			end else begin : g_mid
				assign down_entry = cell_entry[i+1];
			end

			srpq_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.is_head   ((i == 0) ? 1'b1 : 1'b0),
				.up        (up_entry),
				.up_valid  (up_ok),
				.down      (down_entry),
				.own_valid (cell_valid[i]),
				.entry     (cell_entry[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= start;
			if (cmd.ins) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pull) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Status and pulled value are captured with the item; the rest is read live.
	always_ff @(posedge clk) begin
		if (start) begin
			if (request.operation == OP_INSERT) begin
				status_q <= is_full ? ST_FULL : ST_OK;
				pulled_q <= '0;
			end else begin
				status_q <= is_empty ? ST_EMPTY : ST_OK;
				pulled_q <= is_empty ? '0 : cell_entry[0].value;
			end
		end
	end

	assign done = done_q;

	always_comb begin
		result.status       = status_q;
		result.pulled_value = pulled_q;
		result.head_value   = is_empty ? '0 : cell_entry[0].value;
		result.entry_count  = COUNT_W'(count_q);
	end

endmodule

@@ tb/sv/sorted_ring_priority_queue_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the sorted ring priority queue.
//
// Items are driven at the falling clock edge and both handshakes are observed
// at the rising edge. The queue_scoreboard object keeps its own sorted copy of
// the queue contents. For every accepted item it works out the result that the
// block must return. Each result that comes back with done is compared field
// by field against the oldest outstanding prediction.

module sorted_ring_priority_queue_test;
	import srpq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	// This many cycles in a row with no accepted item and no result count as a hang.
	localparam int HANG_LIMIT  = 2000;

	// Reference copy of the queue. Entries are held in leaving order, so
	// index 0 is always the head.
	class queue_scoreboard;
		entry_t held[$];
		rsp_t   owed[$];
		int     mismatches;
		int     checked;
		int     inserts_done;
		int     pulls_done;
		int     full_rejects;
		int     empty_rejects;
		int     deepest;

		function new();
			mismatches    = 0;
			checked       = 0;
			inserts_done  = 0;
			pulls_done    = 0;
			full_rejects  = 0;
			empty_rejects = 0;
			deepest       = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Applies one accepted item to the reference copy and queues the result
		// that the block owes for it.
		function void note_request(req_t r);
			rsp_t   want;
			entry_t fresh;
			int     pos;
			want        = '0;
			want.status = ST_OK;
			if (r.operation == OP_INSERT) begin
				if (held.size() >= QUEUE_DEPTH) begin
					want.status = ST_FULL;
					full_rejects++;
				end else begin
					// The new entry goes behind every entry of greater or equal
					// priority, so walk up from the tail past the weaker ones.
					fresh.prio  = r.item_priority;
					fresh.value = r.item_value;
					pos = held.size();
					while (pos > 0 && $signed(r.item_priority) > $signed(held[pos-1].prio))
						pos--;
					held.insert(pos, fresh);
					inserts_done++;
				end
			end else begin
				if (held.size() == 0) begin
					want.status = ST_EMPTY;
					empty_rejects++;
				end else begin
					fresh             = held.pop_front();
					want.pulled_value = fresh.value;
					pulls_done++;
				end
			end
			if (held.size() > deepest)
				deepest = held.size();
			want.head_value  = (held.size() != 0) ? held[0].value : '0;
			want.entry_count = COUNT_W'(held.size());
			owed.push_back(want);
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
			mismatches++;
		endfunction

		// Compares one result from the block with the oldest prediction.
		function void check_response(rsp_t got);
			rsp_t want;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing outstanding: status %0d pulled 0x%0h",
					$time, got.status, got.pulled_value);
				mismatches++;
				return;
			end
			want = owed.pop_front();
			checked++;
			if (got.status !== want.status)
				report("status", 32'(want.status), 32'(got.status));
			if (got.pulled_value !== want.pulled_value)
				report("pulled_value", want.pulled_value, got.pulled_value);
			if (got.head_value !== want.head_value)
				report("head_value", want.head_value, got.head_value);
			if (got.entry_count !== want.entry_count)
				report("entry_count", 32'(want.entry_count), 32'(got.entry_count));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;

	queue_scoreboard sb;
	int accepted_items;
	int quiet_cycles;

	sorted_ring_priority_queue #(
		.DEPTH(QUEUE_DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	// A 20 ns clock with its rising edge at 10 ns.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Both handshakes are observed at the rising edge. The result is checked
	// before the new item is noted, so a stray done can never be paired with
	// the item that is accepted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_response(result);
			if (start && !busy) begin
				sb.note_request(request);
				accepted_items++;
			end
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Ends the run if nothing moves for too long.
	initial begin
		while (quiet_cycles < HANG_LIMIT)
			@(posedge clk);
		$display("%0t: no item or result accepted for %0d cycles", $time, HANG_LIMIT);
		$display("** sorted_ring_priority_queue: FAILED **");
		$finish;
	end

	// Presents one item after a random number of idle cycles and holds it until
	// the block takes it. The task returns at the falling edge after acceptance,
	// where nothing has been driven yet in that time step.
	task automatic send_request(input req_t r, input int idle_pct);
		int want_count;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		request    <= r;
		want_count  = accepted_items + 1;
		do
			@(negedge clk);
		while (accepted_items < want_count);
	endtask

	// Stops sending and waits until every outstanding result has come back.
	task automatic drain_results();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic req_t make_insert(logic [31:0] value, logic signed [15:0] prio);
		req_t r;
		r.operation     = OP_INSERT;
		r.item_value    = value;
		r.item_priority = prio;
		return r;
	endfunction

	// A pull carries random payload, which the block must ignore.
	function automatic req_t make_pull();
		req_t r;
		r.operation     = OP_PULL;
		r.item_value    = $urandom;
		r.item_priority = 16'($urandom);
		return r;
	endfunction

	// Priorities mix the two extremes, a narrow band of values that makes ties
	// common, and fully random values.
	function automatic logic signed [15:0] pick_priority();
		logic signed [15:0] p;
		case ($urandom_range(9))
			0: p = 16'sh8000;
			1: p = 16'sh7fff;
			2, 3, 4: p = 16'($urandom_range(4)) - 16'sd2;
			default: p = 16'($urandom);
		endcase
		return p;
	endfunction

	// Opens with a pull from the empty queue, then checks value and priority
	// extremes and the order of equal priorities. It fills the queue to the
	// top, tries one insert too many, and pulls a few entries back out.
	task automatic run_directed(input int idle_pct);
		int k;
		send_request(make_pull(), idle_pct);
		send_request(make_insert(32'h0000_0000, 16'sh8000), idle_pct);
		send_request(make_insert(32'hffff_ffff, 16'sh7fff), idle_pct);
		send_request(make_insert(32'h1234_5678, 16'sh0000), idle_pct);
		send_request(make_insert(32'h8765_4321, -16'sd1), idle_pct);
		send_request(make_pull(), idle_pct);
		// Equal priorities must leave in arrival order. A few stronger entries
		// are interleaved so that the ties land mid-queue.
		for (k = 0; k < 13; k++) begin
			if (k % 4 == 3)
				send_request(make_insert($urandom, 16'sh7fff), idle_pct);
			else
				send_request(make_insert(32'ha000_0000 + k, 16'sd5), idle_pct);
		end
		send_request(make_insert(32'hdead_beef, 16'sh7fff), idle_pct);
		for (k = 0; k < 5; k++)
			send_request(make_pull(), idle_pct);
	endtask

	// Random traffic in bursts. Each burst leans toward inserts, toward pulls
	// or toward neither, so the queue swings between empty and full.
	task automatic run_random(input int count, input int idle_pct);
		int k;
		int insert_pct;
		insert_pct = 50;
		for (k = 0; k < count; k++) begin
			if (k % 24 == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 80;
					1: insert_pct = 25;
					default: insert_pct = 50;
				endcase
			end
			if ($urandom_range(99) < insert_pct)
				send_request(make_insert($urandom, pick_priority()), idle_pct);
			else
				send_request(make_pull(), idle_pct);
		end
	endtask

	initial begin
		sb             = new();
		accepted_items = 0;
		quiet_cycles   = 0;
		arst_n         = 1'b0;
		start          = 1'b0;
		request        = '0;
		// Reset is released at a falling edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed(32);
		// The first random phase has a busy sender, the second an idle one,
		// and the third sends back to back.
		run_random(140, 32);
		// Hold off until the queue has answered everything that is outstanding.
		drain_results();
		@(negedge clk);
		run_random(140, 61);
		run_random(145, 0);
		drain_results();
		// A margin to catch any stray result.
		repeat (4) @(negedge clk);

		$display("Sent %0d items: %0d inserts, %0d pulls, %0d full inserts, %0d empty pulls.",
			accepted_items, sb.inserts_done, sb.pulls_done, sb.full_rejects, sb.empty_rejects);
		$display("Checked %0d results; the queue held up to %0d entries; %0d mismatches.",
			sb.checked, sb.deepest, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("** sorted_ring_priority_queue: PASSED **");
		end else begin
			$display("** sorted_ring_priority_queue: FAILED **");
		end
		$finish;
	end

endmodule
